[sv/assert_macros.svh]
// assertion macros shared by the classifier rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, idle during reset
`define PDIO_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pdio assertion failed");

// next-cycle implication, idle during reset
`define PDIO_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pdio assertion failed");

`endif

[sv/pdio_pkg.sv]
// types and constants of the per-device io pattern classifier
package pdio_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int CFG_IDX_W         = 4;
  localparam int CFG_DATA_W        = 32;
  localparam int DEV_W             = 32;
  localparam int SECTOR_W          = 64;
  localparam int COUNT_W           = 32;
  localparam int TOTAL_W           = 64;
  localparam int SLOT_OUT_W        = 6;
  localparam int SECTOR_SHIFT      = 9;

  typedef enum logic [2:0] {
    OUT_FILTERED     = 3'd0,
    OUT_DROPPED      = 3'd1,
    OUT_UNCLASSIFIED = 3'd2,
    OUT_SEQUENTIAL   = 3'd3,
    OUT_RANDOM       = 3'd4
  } outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_ENABLE = 4'd0,
    CFG_TARGET_DEVICE = 4'd1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic             valid;
    logic [DEV_W-1:0] dev;
  } tag_entry_t;

  typedef struct packed {
    logic [SECTOR_W-1:0] last_end;
    logic [TOTAL_W-1:0]  seq;
    logic [TOTAL_W-1:0]  rnd;
    logic [TOTAL_W-1:0]  bytes;
  } slot_rec_t;

endpackage

[sv/pdio_tag_mem.sv]
// device tag memory: valid flag and device id per slot, one write and one read port
module pdio_tag_mem #(
  parameter int ENTRIES = pdio_pkg::TABLE_ENTRIES_DEF,
  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [IDX_W-1:0]     waddr,
  input  pdio_pkg::tag_entry_t wdata,
  input  logic [IDX_W-1:0]     raddr,
  output pdio_pkg::tag_entry_t rdata
);
  import pdio_pkg::*;

  tag_entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/pdio_slot_mem.sv]
// per-slot record memory: last end sector and the three totals
module pdio_slot_mem #(
  parameter int ENTRIES = pdio_pkg::TABLE_ENTRIES_DEF,
  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                clk,
  input  logic                we,
  input  logic [IDX_W-1:0]    waddr,
  input  pdio_pkg::slot_rec_t wdata,
  input  logic [IDX_W-1:0]    raddr,
  output pdio_pkg::slot_rec_t rdata
);
  import pdio_pkg::*;

  slot_rec_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/pdio_update.sv]
// classification and record update for one event
module pdio_update (
  input  pdio_pkg::slot_rec_t                   rd_rec,
  input  logic                                  fresh,
  input  logic [pdio_pkg::SECTOR_W-1:0]         start_sector,
  input  logic [pdio_pkg::COUNT_W-1:0]          sector_count,
  output pdio_pkg::slot_rec_t                   wr_rec,
  output pdio_pkg::outcome_t                    outcome
);
  import pdio_pkg::*;

  slot_rec_t            cur;
  logic [TOTAL_W-1:0]   byte_inc;

  // count * 512 kept to 32 bits
  assign byte_inc = {32'b0, sector_count[COUNT_W-SECTOR_SHIFT-1:0], {SECTOR_SHIFT{1'b0}}};
  // a freshly claimed slot reads as zeroed
  assign cur = fresh ? '0 : rd_rec;

  always_comb begin
    wr_rec  = cur;
    outcome = OUT_UNCLASSIFIED;
    if (cur.last_end != '0) begin
      if (cur.last_end == start_sector) begin
        wr_rec.seq = cur.seq + TOTAL_W'(1);
        outcome    = OUT_SEQUENTIAL;
      end else begin
        wr_rec.rnd = cur.rnd + TOTAL_W'(1);
        outcome    = OUT_RANDOM;
      end
      wr_rec.bytes = cur.bytes + byte_inc;
    end
    wr_rec.last_end = start_sector + {32'b0, sector_count};
  end

endmodule

[sv/per_device_io_pattern_classifier_core.sv]
// top level: control sequencer, config registers and output register of the classifier
//
//  channel   ports                                   handshake
//  input     in_device_id, in_start_sector,          start high while busy low
//            in_sector_count
//  result    out_outcome, out_entry_slot, out_*_total  out_valid, one cycle
//  config    cfg_we, cfg_index, cfg_data              cfg_we, no wait
//
//  a filtered event reports in the cycle after start; any other event scans the tag
//  memory one slot per cycle through the single tag read port until it hits or has
//  checked every slot; a hit or a claim of the lowest free slot then reads and
//  updates the slot record before reporting, and a full table drops the event.
//  after reset a clearing pass resets every tag, busy is high.
//  results are presented for one cycle and cannot be stalled.
`include "assert_macros.svh"

module per_device_io_pattern_classifier_core #(
  parameter int TABLE_ENTRIES = pdio_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [pdio_pkg::DEV_W-1:0]        in_device_id,
  input  logic [pdio_pkg::SECTOR_W-1:0]     in_start_sector,
  input  logic [pdio_pkg::COUNT_W-1:0]      in_sector_count,
  output logic                              out_valid,
  output logic [2:0]                        out_outcome,
  output logic [pdio_pkg::SLOT_OUT_W-1:0]   out_entry_slot,
  output logic [pdio_pkg::TOTAL_W-1:0]      out_sequential_total,
  output logic [pdio_pkg::TOTAL_W-1:0]      out_random_total,
  output logic [pdio_pkg::TOTAL_W-1:0]      out_byte_total,
  input  logic                              cfg_we,
  input  logic [pdio_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pdio_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pdio_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [CNT_W-1:0]     rd_cnt_r, rd_cnt_nxt;
  logic                 chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]     chk_idx_r, chk_idx_nxt;
  logic                 free_found_r, free_found_nxt;
  logic [IDX_W-1:0]     free_idx_r, free_idx_nxt;
  logic [IDX_W-1:0]     slot_r, slot_nxt;
  logic                 fresh_r, fresh_nxt;
  logic                 filter_en_r, filter_en_nxt;
  logic [DEV_W-1:0]     target_r, target_nxt;

  logic [DEV_W-1:0]     dev_r;
  logic [SECTOR_W-1:0]  start_sec_r;
  logic [COUNT_W-1:0]   count_r;
  logic                 latch_in;

  logic                 out_valid_r, out_valid_nxt;
  outcome_t             out_outcome_r, out_outcome_nxt;
  logic [IDX_W-1:0]     out_slot_r, out_slot_nxt;
  logic [TOTAL_W-1:0]   out_seq_r, out_seq_nxt;
  logic [TOTAL_W-1:0]   out_rnd_r, out_rnd_nxt;
  logic [TOTAL_W-1:0]   out_bytes_r, out_bytes_nxt;

  logic                 tag_we;
  logic [IDX_W-1:0]     tag_waddr;
  tag_entry_t           tag_wdata;
  logic [IDX_W-1:0]     tag_raddr;
  tag_entry_t           tag_rdata;

  logic                 slot_we;
  slot_rec_t            slot_rdata;
  slot_rec_t            upd_rec;
  outcome_t             upd_outcome;

  logic                 tag_hit;
  logic [IDX_W-1:0]     claim_idx;

  pdio_tag_mem #(.ENTRIES(TABLE_ENTRIES)) u_tag_mem (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  pdio_slot_mem #(.ENTRIES(TABLE_ENTRIES)) u_slot_mem (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_r),
    .wdata (upd_rec),
    .raddr (slot_r),
    .rdata (slot_rdata)
  );

  pdio_update u_update (
    .rd_rec       (slot_rdata),
    .fresh        (fresh_r),
    .start_sector (start_sec_r),
    .sector_count (count_r),
    .wr_rec       (upd_rec),
    .outcome      (upd_outcome)
  );

  assign busy                 = (state_r != ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_outcome          = out_outcome_r;
  assign out_entry_slot       = SLOT_OUT_W'(out_slot_r);
  assign out_sequential_total = out_seq_r;
  assign out_random_total     = out_rnd_r;
  assign out_byte_total       = out_bytes_r;

  assign tag_hit   = tag_rdata.valid && (tag_rdata.dev == dev_r);
  assign claim_idx = free_found_r ? free_idx_r : chk_idx_r;

  always_comb begin
    filter_en_nxt = filter_en_r;
    target_nxt    = target_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_FILTER_ENABLE: filter_en_nxt = cfg_data[0];
        CFG_TARGET_DEVICE: target_nxt    = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt       = state_r;
    clr_cnt_nxt     = clr_cnt_r;
    rd_cnt_nxt      = rd_cnt_r;
    chk_vld_nxt     = 1'b0;
    chk_idx_nxt     = chk_idx_r;
    free_found_nxt  = free_found_r;
    free_idx_nxt    = free_idx_r;
    slot_nxt        = slot_r;
    fresh_nxt       = fresh_r;
    latch_in        = 1'b0;
    tag_we          = 1'b0;
    tag_waddr       = clr_cnt_r[IDX_W-1:0];
    tag_wdata       = '0;
    tag_raddr       = rd_cnt_r[IDX_W-1:0];
    slot_we         = 1'b0;
    out_valid_nxt   = 1'b0;
    out_outcome_nxt = out_outcome_r;
    out_slot_nxt    = out_slot_r;
    out_seq_nxt     = out_seq_r;
    out_rnd_nxt     = out_rnd_r;
    out_bytes_nxt   = out_bytes_r;

    unique case (state_r)
      ST_CLEAR: begin
        tag_we = 1'b1;
        if (clr_cnt_r == CNT_W'(TABLE_ENTRIES - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + CNT_W'(1);
        end
      end
      ST_IDLE: begin
        if (start) begin
          latch_in = 1'b1;
          if (filter_en_r && (target_r != in_device_id)) begin
            out_valid_nxt   = 1'b1;
            out_outcome_nxt = OUT_FILTERED;
            out_slot_nxt    = '0;
            out_seq_nxt     = '0;
            out_rnd_nxt     = '0;
            out_bytes_nxt   = '0;
          end else begin
            state_nxt      = ST_SCAN;
            rd_cnt_nxt     = '0;
            free_found_nxt = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        // issue the next tag read while checking the one returned from last cycle
        if (rd_cnt_r < CNT_W'(TABLE_ENTRIES)) begin
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = rd_cnt_r[IDX_W-1:0];
          rd_cnt_nxt  = rd_cnt_r + CNT_W'(1);
        end
        if (chk_vld_r) begin
          if (tag_hit) begin
            slot_nxt  = chk_idx_r;
            fresh_nxt = 1'b0;
            state_nxt = ST_READ;
          end else begin
            if (!tag_rdata.valid && !free_found_r) begin
              free_found_nxt = 1'b1;
              free_idx_nxt   = chk_idx_r;
            end
            if (chk_idx_r == IDX_W'(TABLE_ENTRIES - 1)) begin
              if (free_found_r || !tag_rdata.valid) begin
                // claim the lowest free slot
                tag_we          = 1'b1;
                tag_waddr       = claim_idx;
                tag_wdata.valid = 1'b1;
                tag_wdata.dev   = dev_r;
                slot_nxt        = claim_idx;
                fresh_nxt       = 1'b1;
                state_nxt       = ST_READ;
              end else begin
                out_valid_nxt   = 1'b1;
                out_outcome_nxt = OUT_DROPPED;
                out_slot_nxt    = '0;
                out_seq_nxt     = '0;
                out_rnd_nxt     = '0;
                out_bytes_nxt   = '0;
                state_nxt       = ST_IDLE;
              end
            end
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        slot_we         = 1'b1;
        out_valid_nxt   = 1'b1;
        out_outcome_nxt = upd_outcome;
        out_slot_nxt    = slot_r;
        out_seq_nxt     = upd_rec.seq;
        out_rnd_nxt     = upd_rec.rnd;
        out_bytes_nxt   = upd_rec.bytes;
        state_nxt       = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      rd_cnt_r     <= '0;
      chk_vld_r    <= 1'b0;
      chk_idx_r    <= '0;
      free_found_r <= 1'b0;
      free_idx_r   <= '0;
      slot_r       <= '0;
      fresh_r      <= 1'b0;
      filter_en_r  <= 1'b0;
      target_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      rd_cnt_r     <= rd_cnt_nxt;
      chk_vld_r    <= chk_vld_nxt;
      chk_idx_r    <= chk_idx_nxt;
      free_found_r <= free_found_nxt;
      free_idx_r   <= free_idx_nxt;
      slot_r       <= slot_nxt;
      fresh_r      <= fresh_nxt;
      filter_en_r  <= filter_en_nxt;
      target_r     <= target_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (latch_in) begin
      dev_r       <= in_device_id;
      start_sec_r <= in_start_sector;
      count_r     <= in_sector_count;
    end
    out_outcome_r <= out_outcome_nxt;
    out_slot_r    <= out_slot_nxt;
    out_seq_r     <= out_seq_nxt;
    out_rnd_r     <= out_rnd_nxt;
    out_bytes_r   <= out_bytes_nxt;
  end

  `PDIO_ASSERT_NXT(a_accept_progress, start && !busy, (state_r != ST_IDLE) || out_valid)
  `PDIO_ASSERT_NXT(a_update_reports, state_r == ST_UPDATE, out_valid && (out_slot_r == $past(slot_r)))
  `PDIO_ASSERT_IMP(a_slot_write_in_update, slot_we, state_r == ST_UPDATE)
  `PDIO_ASSERT_IMP(a_skip_zero_totals,
    out_valid && (out_outcome == OUT_FILTERED || out_outcome == OUT_DROPPED),
    (out_entry_slot == '0) && (out_sequential_total == '0) &&
    (out_random_total == '0) && (out_byte_total == '0))

endmodule
